@@ rtl/axis_angle_to_rotation_matrix_defines.svh @@
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define AAR_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("axis_angle_to_rotation_matrix: same-cycle check failed");

// Check that holds in the cycle after its condition.
`define AAR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("axis_angle_to_rotation_matrix: next-cycle check failed");

`endif

@@ rtl/aar_pkg.sv @@
`default_nettype none

package aar_pkg;

    // Output fraction bits and number of CORDIC iterations.
    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    // Pipeline depths of the individual units.
    localparam int SQRT_LAT = 32;
    localparam int DIV_LAT  = 31;
    localparam int MAT_LAT  = 3;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [15:0]        angle;
    } aar_in_t;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic               zero_axis;
    } aar_out_t;

endpackage

`default_nettype wire

@@ rtl/axis_angle_to_rotation_matrix.sv @@
`default_nettype none

// Axis-angle to 3x3 rotation matrix. Each item carries an axis of any length
// and a 16-bit binary angle; the result item holds the nine matrix entries in
// Q1.14 and a flag that is set, with the identity given, when the axis is
// exactly zero. The block is a fully pipelined datapath: it takes one item in
// every cycle while no finished result is waiting to be taken. A result
// leaves the end of a chain of 67 registers, the first of which loads at the
// accepting edge: one input stage for the squared length, 32 stages of the
// bit-per-stage square root, 31 stages of the three bit-per-stage dividers
// that scale the axis to unit length, and three stages for the quaternion,
// the pair products and the final rounding. The CORDIC for the half-angle
// sine and cosine runs alongside the square root. The whole pipeline advances
// together; when a finished result is not taken, all stages hold and no new
// item is accepted until it is.

`include "axis_angle_to_rotation_matrix_defines.svh"

module axis_angle_to_rotation_matrix
    import aar_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    input  wire aar_in_t req,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output aar_out_t     rsp
);

    localparam int LAT    = 1 + SQRT_LAT + DIV_LAT + MAT_LAT;
    localparam int FLAG_N = SQRT_LAT + DIV_LAT;
    localparam int SC_N   = SQRT_LAT + DIV_LAT - CORDIC_N;

    // The pipeline moves whenever the output slot is free or being emptied.
    logic en;
    logic [LAT-1:0] vld_reg;

    assign en        = !vld_reg[LAT-1] || rsp_ready;
    assign req_ready = en;
    assign rsp_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], req_valid};
        end
    end

    // Input stage: component magnitudes, signs and the squared length.
    logic [15:0] mag_x, mag_y, mag_z;
    logic [31:0] n2_next;

    assign mag_x   = req.axis_x[15] ? 16'(-req.axis_x) : req.axis_x;
    assign mag_y   = req.axis_y[15] ? 16'(-req.axis_y) : req.axis_y;
    assign mag_z   = req.axis_z[15] ? 16'(-req.axis_z) : req.axis_z;
    assign n2_next = 32'(mag_x) * 32'(mag_x) + 32'(mag_y) * 32'(mag_y)
                   + 32'(mag_z) * 32'(mag_z);

    logic [31:0] n2_reg;
    logic [47:0] mag_reg;
    logic [2:0]  neg_reg;
    logic        zero_reg;
    logic [15:0] angle_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            n2_reg    <= n2_next;
            mag_reg   <= {mag_x, mag_y, mag_z};
            neg_reg   <= {req.axis_x[15], req.axis_y[15], req.axis_z[15]};
            zero_reg  <= (req.axis_x == '0) && (req.axis_y == '0) && (req.axis_z == '0);
            angle_reg <= req.angle;
        end
    end

    // Side lines that keep the other operands level with the long units.
    logic [47:0] mag_dly_reg  [0:SQRT_LAT-1];
    logic [3:0]  flag_dly_reg [0:FLAG_N-1];
    logic [63:0] sc_dly_reg   [0:SC_N-1];
    logic signed [31:0] sin_h, cos_h;

    always_ff @(posedge clk) begin
        if (en) begin
            mag_dly_reg[0]  <= mag_reg;
            flag_dly_reg[0] <= {neg_reg, zero_reg};
            sc_dly_reg[0]   <= {sin_h, cos_h};
            for (int k = 1; k < SQRT_LAT; k++) begin
                mag_dly_reg[k] <= mag_dly_reg[k-1];
            end
            for (int k = 1; k < FLAG_N; k++) begin
                flag_dly_reg[k] <= flag_dly_reg[k-1];
            end
            for (int k = 1; k < SC_N; k++) begin
                sc_dly_reg[k] <= sc_dly_reg[k-1];
            end
        end
    end

    logic [31:0] root;

    aar_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .n2   (n2_reg),
        .root (root)
    );

    aar_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .angle (angle_reg),
        .sin_h (sin_h),
        .cos_h (cos_h)
    );

    logic [30:0] quo_x, quo_y, quo_z;
    logic [47:0] mag_d;

    assign mag_d = mag_dly_reg[SQRT_LAT-1];

    aar_div u_div_x (
        .clk (clk),
        .en  (en),
        .s   (root),
        .mag (mag_d[47:32]),
        .quo (quo_x)
    );

    aar_div u_div_y (
        .clk (clk),
        .en  (en),
        .s   (root),
        .mag (mag_d[31:16]),
        .quo (quo_y)
    );

    aar_div u_div_z (
        .clk (clk),
        .en  (en),
        .s   (root),
        .mag (mag_d[15:0]),
        .quo (quo_z)
    );

    logic [3:0]  flag_d;
    logic [63:0] sc_d;

    assign flag_d = flag_dly_reg[FLAG_N-1];
    assign sc_d   = sc_dly_reg[SC_N-1];

    aar_mat u_mat (
        .clk   (clk),
        .en    (en),
        .quo_x (quo_x),
        .quo_y (quo_y),
        .quo_z (quo_z),
        .neg   (flag_d[3:1]),
        .zero  (flag_d[0]),
        .sin_h ($signed(sc_d[63:32])),
        .cos_h ($signed(sc_d[31:0])),
        .rsp   (rsp)
    );

    // A non-zero axis always has a root of at least 2^16 at the divider input.
    `AAR_ASSERT_NOW(a_root_nonzero, vld_reg[SQRT_LAT] && !flag_dly_reg[SQRT_LAT-1][0], root != '0)

    // A zero axis yields the identity.
    `AAR_ASSERT_NOW(a_zero_identity, rsp_valid && rsp.zero_axis, rsp.rot_01 == '0 && rsp.rot_02 == '0 && rsp.rot_10 == '0 && rsp.rot_12 == '0 && rsp.rot_20 == '0 && rsp.rot_21 == '0 && rsp.rot_00 == rsp.rot_11 && rsp.rot_11 == rsp.rot_22)

    // While the pipeline is held, no item moves or vanishes.
    `AAR_ASSERT_NEXT(a_hold_pipe, !en, $stable(vld_reg))

endmodule

`default_nettype wire

@@ rtl/aar_sqrt.sv @@
`default_nettype none

// Floor square root of n2 * 2^32, one result bit per stage.
module aar_sqrt
    import aar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] n2,
    output logic [31:0]      root
);

    logic [33:0] rem_reg  [0:SQRT_LAT-1];
    logic [31:0] root_reg [0:SQRT_LAT-1];
    logic [31:0] rad_reg  [0:SQRT_LAT-1];

    genvar k;
    for (k = 0; k < SQRT_LAT; k++) begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [31:0] rad_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = n2;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in, rad_in[31:30]};
            trial  = {2'b00, root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = 34'(rem_sh - trial);
                root_next = {root_in[30:0], 1'b1};
            end else begin
                rem_next  = rem_sh[33:0];
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_in[29:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

`default_nettype wire

@@ rtl/aar_div.sv @@
`default_nettype none

// Rounded quotient (mag * 2^46 + s/2) / s, one quotient bit per stage.
// The quotient is known to stay below 2^31 for a non-zero axis.
module aar_div
    import aar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] s,
    input  wire logic [15:0] mag,
    output logic [30:0]      quo
);

    logic [31:0] rem_reg [0:DIV_LAT-1];
    logic [30:0] quo_reg [0:DIV_LAT-1];
    logic [30:0] low_reg [0:DIV_LAT-1];
    logic [31:0] div_reg [0:DIV_LAT-1];
    logic [61:0] dividend;

    // The half divisor only fills the zero low bits, so no adder is needed.
    assign dividend = {mag, 46'b0} | {31'b0, s[31:1]};

    genvar k;
    for (k = 0; k < DIV_LAT; k++) begin : g_stage
        logic [31:0] rem_in;
        logic [30:0] quo_in;
        logic [30:0] low_in;
        logic [31:0] div_in;
        logic [32:0] rem_sh;
        logic [31:0] rem_next;
        logic [30:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in = {1'b0, dividend[61:31]};
            assign quo_in = '0;
            assign low_in = dividend[30:0];
            assign div_in = s;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign low_in = low_reg[k-1];
            assign div_in = div_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in, low_in[30]};
            if (rem_sh >= {1'b0, div_in}) begin
                rem_next = 32'(rem_sh - {1'b0, div_in});
                quo_next = {quo_in[29:0], 1'b1};
            end else begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_in[29:0], 1'b0};
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                low_reg[k] <= {low_in[29:0], 1'b0};
                div_reg[k] <= div_in;
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];

endmodule

`default_nettype wire

@@ rtl/aar_cordic.sv @@
`default_nettype none

// Rotation-mode CORDIC giving sine and cosine of half the input angle in Q30.
module aar_cordic
    import aar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] angle,
    output logic signed [31:0] sin_h,
    output logic signed [31:0] cos_h
);

    localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;
    localparam logic signed [33:0] X_START  = 34'sd652032874;

    function automatic logic signed [33:0] aar_atan(input int idx);
        logic signed [33:0] r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [33:0] c;
        if (v > Q30_ONE) begin
            c = Q30_ONE;
        end else if (v < -Q30_ONE) begin
            c = -Q30_ONE;
        end else begin
            c = v;
        end
        return c[31:0];
    endfunction

    logic signed [33:0] x_reg [0:CORDIC_N-1];
    logic signed [33:0] y_reg [0:CORDIC_N-1];
    logic signed [33:0] z_reg [0:CORDIC_N-1];

    genvar i;
    for (i = 0; i < CORDIC_N; i++) begin : g_stage
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [33:0] z_in;
        logic signed [33:0] x_next;
        logic signed [33:0] y_next;
        logic signed [33:0] z_next;

        if (i == 0) begin : g_first
            // Half angle less a quarter turn, as a 32-bit binary angle.
            assign x_in = X_START;
            assign y_in = '0;
            assign z_in = $signed({3'b000, angle, 15'b0}) - Q30_ONE;
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
        end

        always_comb begin
            if (!z_in[33]) begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - aar_atan(i);
            end else begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + aar_atan(i);
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign sin_h = clamp_q30(x_reg[CORDIC_N-1]);
    assign cos_h = clamp_q30(-y_reg[CORDIC_N-1]);

endmodule

`default_nettype wire

@@ rtl/aar_mat.sv @@
`default_nettype none

// Quaternion and matrix stages: vector part, pair products, then rounding.
module aar_mat
    import aar_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [30:0]        quo_x,
    input  wire logic [30:0]        quo_y,
    input  wire logic [30:0]        quo_z,
    input  wire logic [2:0]         neg,
    input  wire logic               zero,
    input  wire logic signed [31:0] sin_h,
    input  wire logic signed [31:0] cos_h,
    output aar_out_t                rsp
);

    localparam logic [30:0]        U_MAX   = 31'd1073741824;
    localparam logic signed [35:0] ONE_36  = 36'sd1073741824;
    localparam int                 RND_SH  = 30 - FRAC_BITS;
    localparam logic signed [35:0] HALF    = 36'((64'd1 << RND_SH) >> 1);
    localparam logic signed [35:0] LIM     = 36'sd1 <<< FRAC_BITS;

    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

    function automatic logic signed [31:0] unit_of(input logic [30:0] q, input logic n);
        logic [30:0]        c;
        logic signed [31:0] u;
        c = (q > U_MAX) ? U_MAX : q;
        u = $signed({1'b0, c});
        return n ? -u : u;
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + HALF) >>> RND_SH;
        if (t > LIM) begin
            t = LIM;
        end else if (t < -LIM) begin
            t = -LIM;
        end
        return t[15:0];
    endfunction

    // First stage: quaternion.
    logic signed [31:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic               zero1_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            qx_reg    <= mul_q30(unit_of(quo_x, neg[2]), sin_h);
            qy_reg    <= mul_q30(unit_of(quo_y, neg[1]), sin_h);
            qz_reg    <= mul_q30(unit_of(quo_z, neg[0]), sin_h);
            qw_reg    <= cos_h;
            zero1_reg <= zero;
        end
    end

    // Second stage: the nine pair products.
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    logic               zero2_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            xx_reg    <= mul_q30(qx_reg, qx_reg);
            yy_reg    <= mul_q30(qy_reg, qy_reg);
            zz_reg    <= mul_q30(qz_reg, qz_reg);
            xy_reg    <= mul_q30(qx_reg, qy_reg);
            xz_reg    <= mul_q30(qx_reg, qz_reg);
            yz_reg    <= mul_q30(qy_reg, qz_reg);
            wx_reg    <= mul_q30(qw_reg, qx_reg);
            wy_reg    <= mul_q30(qw_reg, qy_reg);
            wz_reg    <= mul_q30(qw_reg, qz_reg);
            zero2_reg <= zero1_reg;
        end
    end

    // Third stage: matrix entries, rounded and saturated.
    logic signed [35:0] m_next [0:8];
    aar_out_t           rsp_next;
    aar_out_t           rsp_reg;

    always_comb begin
        if (zero2_reg) begin
            m_next[0] = ONE_36;
            m_next[1] = '0;
            m_next[2] = '0;
            m_next[3] = '0;
            m_next[4] = ONE_36;
            m_next[5] = '0;
            m_next[6] = '0;
            m_next[7] = '0;
            m_next[8] = ONE_36;
        end else begin
            m_next[0] = ONE_36 - 36'sd2 * (36'(yy_reg) + 36'(zz_reg));
            m_next[1] = 36'sd2 * (36'(xy_reg) + 36'(wz_reg));
            m_next[2] = 36'sd2 * (36'(xz_reg) - 36'(wy_reg));
            m_next[3] = 36'sd2 * (36'(xy_reg) - 36'(wz_reg));
            m_next[4] = ONE_36 - 36'sd2 * (36'(xx_reg) + 36'(zz_reg));
            m_next[5] = 36'sd2 * (36'(yz_reg) + 36'(wx_reg));
            m_next[6] = 36'sd2 * (36'(xz_reg) + 36'(wy_reg));
            m_next[7] = 36'sd2 * (36'(yz_reg) - 36'(wx_reg));
            m_next[8] = ONE_36 - 36'sd2 * (36'(xx_reg) + 36'(yy_reg));
        end
        rsp_next.rot_00    = to_out(m_next[0]);
        rsp_next.rot_01    = to_out(m_next[1]);
        rsp_next.rot_02    = to_out(m_next[2]);
        rsp_next.rot_10    = to_out(m_next[3]);
        rsp_next.rot_11    = to_out(m_next[4]);
        rsp_next.rot_12    = to_out(m_next[5]);
        rsp_next.rot_20    = to_out(m_next[6]);
        rsp_next.rot_21    = to_out(m_next[7]);
        rsp_next.rot_22    = to_out(m_next[8]);
        rsp_next.zero_axis = zero2_reg;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for the axis-angle to rotation matrix block.
// Items are queued by an initial block, driven at the falling edge by a
// clocked driver, and every result is checked at the rising edge against a
// matrix predicted in 64-bit integer arithmetic from the same fixed-point
// recipe: a unit axis scaled in Q30, a half-angle CORDIC, a quaternion and
// its pair products, then rounding and saturation to Q1.14.
module tb_top;
    import aar_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    aar_in_t  req;
    logic     rsp_valid;
    logic     rsp_ready;
    aar_out_t rsp;

    axis_angle_to_rotation_matrix dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    localparam longint ONE_Q30  = 64'sd1 << 30;
    localparam int     LATENCY  = 67;
    localparam longint MAX_CYCLES = 400000;

    // Arctangent of 2^-i as a fraction of a quarter turn scaled by 2^30.
    localparam longint ATAN_TAB [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    aar_in_t  pending_items[$];
    aar_out_t expected_matrices[$];
    bit       sender_quiet;      // no idling in the closing part
    bit       hold_sender;       // sender waits for the pipeline to drain
    bit       req_taken;         // an item was accepted at the last rising edge
    int       send_gap;
    int       recv_gap;
    int       errors;
    int       checked;
    int       zero_seen;
    longint   cycle_count;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return shr_floor(a * b + (64'sd1 << 29), 30);
    endfunction

    // Integer square root of a 64-bit unsigned value, one result bit per step.
    function automatic longint unsigned root_u64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint a, longint unsigned s);
        longint unsigned mag;
        longint u;
        mag = (a < 0) ? -a : a;
        u = ((mag << 46) + s / 2) / s;
        if (u > ONE_Q30)
            u = ONE_Q30;
        return (a < 0) ? -u : u;
    endfunction

    function automatic logic signed [15:0] round_out(longint v);
        int sh;
        sh = 30 - FRAC_BITS;
        if (sh > 0)
            v = shr_floor(v + (64'sd1 << (sh - 1)), sh);
        v = clip(v, 64'sd1 << FRAC_BITS);
        return v[15:0];
    endfunction

    function automatic aar_out_t rotation_of(aar_in_t it);
        longint ax, ay, az, m[9];
        longint unsigned s;
        longint ux, uy, uz, cx, cy, cz, dx, dy, chv, shv;
        longint qx, qy, qz, qw, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        aar_out_t o;
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        if (ax == 0 && ay == 0 && az == 0)
        begin
            for (int k = 0; k < 9; k++)
                m[k] = (k % 4 == 0) ? ONE_Q30 : 0;
            o.zero_axis = 1'b1;
        end
        else
        begin
            s = root_u64(longint'(ax * ax + ay * ay + az * az) << 32);
            ux = unit_part(ax, s);
            uy = unit_part(ay, s);
            uz = unit_part(az, s);
            // Rotation-mode CORDIC on the half angle less a quarter turn.
            cx = 64'h26DD3B6A;
            cy = 0;
            cz = (longint'(it.angle) << 15) - ONE_Q30;
            for (int i = 0; i < CORDIC_N; i++)
            begin
                dx = shr_floor(cy, i);
                dy = shr_floor(cx, i);
                if (cz >= 0)
                begin
                    cx -= dx; cy += dy; cz -= ATAN_TAB[i];
                end
                else
                begin
                    cx += dx; cy -= dy; cz += ATAN_TAB[i];
                end
            end
            chv = clip(-cy, ONE_Q30);
            shv = clip(cx, ONE_Q30);
            qx = q30_mul(ux, shv);
            qy = q30_mul(uy, shv);
            qz = q30_mul(uz, shv);
            qw = chv;
            xx = q30_mul(qx, qx); yy = q30_mul(qy, qy); zz = q30_mul(qz, qz);
            xy = q30_mul(qx, qy); xz = q30_mul(qx, qz); yz = q30_mul(qy, qz);
            wx = q30_mul(qw, qx); wy = q30_mul(qw, qy); wz = q30_mul(qw, qz);
            m[0] = ONE_Q30 - 2 * (yy + zz);
            m[1] = 2 * (xy + wz);
            m[2] = 2 * (xz - wy);
            m[3] = 2 * (xy - wz);
            m[4] = ONE_Q30 - 2 * (xx + zz);
            m[5] = 2 * (yz + wx);
            m[6] = 2 * (xz + wy);
            m[7] = 2 * (yz - wx);
            m[8] = ONE_Q30 - 2 * (xx + yy);
            o.zero_axis = 1'b0;
        end
        o.rot_00 = round_out(m[0]); o.rot_01 = round_out(m[1]);
        o.rot_02 = round_out(m[2]); o.rot_10 = round_out(m[3]);
        o.rot_11 = round_out(m[4]); o.rot_12 = round_out(m[5]);
        o.rot_20 = round_out(m[6]); o.rot_21 = round_out(m[7]);
        o.rot_22 = round_out(m[8]);
        return o;
    endfunction

    function automatic aar_in_t make_item(int ax, int ay, int az, int ang);
        aar_in_t it;
        it.axis_x = ax[15:0];
        it.axis_y = ay[15:0];
        it.axis_z = az[15:0];
        it.angle  = ang[15:0];
        return it;
    endfunction

    // Axis component: often small, sometimes an extreme, otherwise anything.
    function automatic int axis_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return -32768;
            2:       return 32767;
            3, 4:    return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: presents the queue head and changes inputs at the falling edge.
    // Acceptance is taken from the rising edge just gone, as the monitor saw it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
                void'(pending_items.pop_front());
            if (!req_valid || req_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_items.size() > 0 && !hold_sender)
                begin
                    req_valid <= 1'b1;
                    req <= pending_items[0];
                    if (!sender_quiet && $urandom_range(0, 19) == 0)
                        send_gap <= $urandom_range(1, 12);
                end
                else
                    req_valid <= 1'b0;
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (!sender_quiet && $urandom_range(0, 19) == 0)
                    recv_gap <= $urandom_range(1, 12);
            end
        end
    end

    // Monitor: records accepted items and checks accepted results.
    always @(posedge clk)
    begin
        aar_out_t want;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            req_taken <= req_valid && req_ready;
            if (req_valid && req_ready)
                expected_matrices.push_back(rotation_of(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_matrices.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    checked++;
                    if (want.zero_axis)
                        zero_seen++;
                    if (rsp !== want)
                    begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, want, rsp);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int ang_set [6] = '{0, 1, 16384, 32768, 49152, 65535};
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        sender_quiet = 1'b0;
        hold_sender = 1'b0;
        req_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        errors = 0;
        checked = 0;
        zero_seen = 0;
        cycle_count = 0;

        // Directed items: the zero axis, the field extremes, single axes,
        // and the angles at each quarter turn.
        pending_items.push_back(make_item(0, 0, 0, 0));
        pending_items.push_back(make_item(0, 0, 0, 12345));
        pending_items.push_back(make_item(-32768, -32768, -32768, 65535));
        pending_items.push_back(make_item(32767, 32767, 32767, 32768));
        pending_items.push_back(make_item(-32768, 32767, 0, 1));
        foreach (ang_set[i])
        begin
            pending_items.push_back(make_item(1, 0, 0, ang_set[i]));
            pending_items.push_back(make_item(0, -1, 0, ang_set[i]));
            pending_items.push_back(make_item(0, 0, 32767, ang_set[i]));
        end
        pending_items.push_back(make_item(-1, -1, -1, 21845));
        for (int i = 0; i < 950; i++)
            pending_items.push_back(make_item(axis_value(), axis_value(),
                                              axis_value(), $urandom_range(0, 65535)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Let the sender run dry, then pause until the pipeline is empty.
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        wait (expected_matrices.size() == 0 && !rsp_valid);
        for (int i = 0; i < 1000; i++)
            pending_items.push_back(make_item(axis_value(), axis_value(),
                                              axis_value(), $urandom_range(0, 65535)));
        @(negedge clk);
        hold_sender = 1'b0;

        // The closing part runs with both sides at full rate.
        wait (pending_items.size() < 200);
        sender_quiet = 1'b1;
        wait (pending_items.size() == 0 && !req_valid);
        wait (expected_matrices.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d rotation matrices, %0d of them for a zero axis,",
                 checked, zero_seen);
        $display("with random stalls on both handshakes and one full drain.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Run stopped by the cycle limit.");
            $display("status: fail");
            $finish;
        end
    end
endmodule
